// ===== rtl/core/quad_motor_mixer_unit_assert.svh =====
// Assertion macros shared by the motor mixer RTL.
`ifndef QUAD_MOTOR_MIXER_UNIT_ASSERT_SVH
`define QUAD_MOTOR_MIXER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QMM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("motor mixer check failed");

// Consequent must hold in the cycle after the antecedent.
`define QMM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("motor mixer check failed");

`endif

// ===== rtl/core/qmm_pkg.sv =====
// Types, constants and lookup tables of the quad motor mixer.
package qmm_pkg;

   localparam int MOTORS    = 4;
   localparam int TAPS      = 4;
   localparam int FRAC_BITS = 14;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int HALF      = ONE / 2;

   // Working width of a motor demand, generous for throttle and scaling.
   localparam int MIX_W  = FRAC_BITS + 6;
   localparam int QB     = FRAC_BITS + 2;
   localparam int NUM_W  = MIX_W + FRAC_BITS + 3;
   localparam int REM_W  = MIX_W + 3;
   localparam int CNT_W  = $clog2(QB);
   localparam int PROD_W = 33;
   localparam int SUM_W  = 17;

   localparam int FILT_UP  = (2 * 5 * ONE + 1000) / 2000;
   localparam int FILT_DN  = (2 * ONE + 100) / 200;
   localparam int FILT_LO  = (2 * ONE + 10) / 20;
   localparam int LIFT_MAX = (4 * ONE + 10) / 20;
   localparam int RED_SHIFT = 20;
   localparam int RED_RECIP = ((1 << RED_SHIFT) + 19) / 20;

   localparam logic [2:0] CSR_GAIN     = 3'd0;
   localparam logic [2:0] CSR_INV_YAW  = 3'd1;
   localparam logic [2:0] CSR_PLUS     = 3'd2;
   localparam logic [2:0] CSR_BRUSHLESS = 3'd3;
   localparam logic [2:0] CSR_IDLE     = 3'd4;
   localparam logic [2:0] CSR_LIMIT    = 3'd5;

   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_LOAD  = 4'd1;
   localparam logic [3:0] OP_MIX   = 4'd2;
   localparam logic [3:0] OP_BOOST = 4'd3;
   localparam logic [3:0] OP_EXT   = 4'd4;
   localparam logic [3:0] OP_DLOAD = 4'd5;
   localparam logic [3:0] OP_DITER = 4'd6;
   localparam logic [3:0] OP_DWB   = 4'd7;
   localparam logic [3:0] OP_THR   = 4'd8;
   localparam logic [3:0] OP_BADD  = 4'd9;
   localparam logic [3:0] OP_BOVER = 4'd10;
   localparam logic [3:0] OP_BRED  = 4'd11;
   localparam logic [3:0] OP_BLIFT = 4'd12;
   localparam logic [3:0] OP_MUL   = 4'd13;
   localparam logic [3:0] OP_ACC   = 4'd14;
   localparam logic [3:0] OP_EMIT  = 4'd15;

   typedef struct packed {
      logic signed [15:0] roll_corr;
      logic signed [15:0] pitch_corr;
      logic signed [15:0] yaw_corr;
      logic [14:0]        throttle_in;
      logic               grounded;
      logic               airborne;
      logic               armed;
   } qmm_req_type;

   typedef struct packed {
      logic [14:0] motor_front_right;
      logic [14:0] motor_front_left;
      logic [14:0] motor_back_right;
      logic [14:0] motor_back_left;
      logic [14:0] throttle_average;
   } qmm_rsp_type;

   typedef struct packed {
      logic [7:0] torque_boost_gain;
      logic       yaw_flip;
      logic       plus_layout;
      logic       brushless_mode;
      logic [6:0] idle_percent;
      logic [6:0] limit_percent;
   } qmm_cfg_type;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] mot;
   } qmm_cmd_type;

   typedef struct packed {
      logic boost_en;
      logic brushless;
      logic skip_scale;
      logic range_big;
   } qmm_status_type;

   typedef logic [14:0] pct_tab_type [128];

   function automatic pct_tab_type build_idle_tab();
      pct_tab_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = 15'((2 * (1 + 100 * i) * ONE + 10000) / 20000);
      end
      return t;
   endfunction

   function automatic pct_tab_type build_limit_tab();
      pct_tab_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = 15'((2 * i * ONE + 100) / 200);
      end
      return t;
   endfunction

   localparam pct_tab_type IDLE_TAB  = build_idle_tab();
   localparam pct_tab_type LIMIT_TAB = build_limit_tab();

   function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
      if (v > 24'sd32767) begin
         return 16'sh7fff;
      end else if (v < -24'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

// ===== rtl/core/qmm_ctrl.sv =====
// Sequencer of the motor mixer: steps the datapath through one transaction.
module qmm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  qmm_pkg::qmm_status_type status,
   output qmm_pkg::qmm_cmd_type    cmd
);
   import qmm_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MIX    = 4'd1;
   localparam logic [3:0] ST_BOOST  = 4'd2;
   localparam logic [3:0] ST_EXT    = 4'd3;
   localparam logic [3:0] ST_DECIDE = 4'd4;
   localparam logic [3:0] ST_DLOAD  = 4'd5;
   localparam logic [3:0] ST_DITER  = 4'd6;
   localparam logic [3:0] ST_DWB    = 4'd7;
   localparam logic [3:0] ST_THR    = 4'd8;
   localparam logic [3:0] ST_BADD   = 4'd9;
   localparam logic [3:0] ST_BOVER  = 4'd10;
   localparam logic [3:0] ST_BRED   = 4'd11;
   localparam logic [3:0] ST_BLIFT  = 4'd12;
   localparam logic [3:0] ST_MUL    = 4'd13;
   localparam logic [3:0] ST_ACC    = 4'd14;
   localparam logic [3:0] ST_EMIT   = 4'd15;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       mot_ff, mot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             scaled_ff, scaled_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       scale_state;

   always_comb begin
      if (!status.brushless) begin
         scale_state = ST_BADD;
      end else if (status.skip_scale) begin
         scale_state = ST_MUL;
      end else begin
         scale_state = ST_EXT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mot_in       = mot_ff;
      cnt_in       = cnt_ff;
      scaled_in    = scaled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.mot      = mot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op    = OP_LOAD;
               mot_in    = '0;
               scaled_in = 1'b0;
               state_in  = ST_MIX;
            end
         end
         ST_MIX: begin
            cmd.op   = OP_MIX;
            state_in = status.boost_en ? ST_BOOST : scale_state;
         end
         ST_BOOST: begin
            cmd.op   = OP_BOOST;
            state_in = scale_state;
         end
         ST_EXT: begin
            cmd.op   = OP_EXT;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (status.range_big && !scaled_ff) ? ST_DLOAD : ST_THR;
         end
         ST_DLOAD: begin
            cmd.op   = OP_DLOAD;
            cnt_in   = '0;
            state_in = ST_DITER;
         end
         ST_DITER: begin
            cmd.op = OP_DITER;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QB - 1)) begin
               state_in = ST_DWB;
            end
         end
         ST_DWB: begin
            cmd.op = OP_DWB;
            mot_in = mot_ff + 1'b1;
            if (mot_ff == 2'(MOTORS - 1)) begin
               scaled_in = 1'b1;
               state_in  = ST_EXT;
            end else begin
               state_in = ST_DLOAD;
            end
         end
         ST_THR: begin
            cmd.op   = OP_THR;
            state_in = ST_MUL;
         end
         ST_BADD: begin
            cmd.op   = OP_BADD;
            state_in = ST_BOVER;
         end
         ST_BOVER: begin
            cmd.op   = OP_BOVER;
            state_in = ST_BRED;
         end
         ST_BRED: begin
            cmd.op   = OP_BRED;
            state_in = ST_BLIFT;
         end
         ST_BLIFT: begin
            cmd.op   = OP_BLIFT;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op = OP_ACC;
            mot_in = mot_ff + 1'b1;
            state_in = (mot_ff == 2'(MOTORS - 1)) ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            // The result register must be empty or draining this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mot_ff       <= '0;
         cnt_ff       <= '0;
         scaled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mot_ff       <= mot_in;
         cnt_ff       <= cnt_in;
         scaled_ff    <= scaled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/qmm_datapath.sv =====
// Datapath of the motor mixer: demand registers, boost filter, divider and output map.
module qmm_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  qmm_pkg::qmm_cfg_type    cfg,
   input  qmm_pkg::qmm_req_type    req_payload,
   input  qmm_pkg::qmm_cmd_type    cmd,
   output qmm_pkg::qmm_status_type status,
   output qmm_pkg::qmm_rsp_type    rsp_payload
);
   import qmm_pkg::*;

   qmm_req_type               req_ff;
   logic signed [MIX_W-1:0]   mix_ff [MOTORS];
   logic signed [MIX_W-1:0]   mix_in [MOTORS];
   logic signed [15:0]        hist_ff [MOTORS][TAPS];
   logic signed [15:0]        hist_in [MOTORS][TAPS];
   logic signed [15:0]        filt_ff, filt_in;
   logic signed [MIX_W-1:0]   mn_ff, mn_in, mx_ff, mx_in;
   logic [REM_W-1:0]          rem_ff, rem_in, den_ff, den_in;
   logic [QB-1:0]             quo_ff, quo_in;
   logic                      neg_ff, neg_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [14:0]               out_ff [MOTORS];
   logic [14:0]               out_in [MOTORS];
   logic [SUM_W-1:0]          sum_ff, sum_in;
   qmm_rsp_type               rsp_ff, rsp_in;

   logic signed [MIX_W:0]     rng;
   logic signed [17:0]        r_s, p_s, y_s;
   logic signed [23:0]        raw [MOTORS];
   logic signed [23:0]        t_s, sum_s;
   logic signed [31:0]        bprod;
   logic signed [NUM_W-1:0]   num;
   logic [NUM_W-1:0]          mag;
   logic [REM_W-1:0]          trial;
   logic signed [MIX_W-1:0]   qv, qc;
   logic signed [MIX_W+1:0]   thr_s, st, lo_b, hi_b;
   logic signed [MIX_W-1:0]   acc, fv;
   logic [16:0]               rx;
   logic [33:0]               rprod;
   logic [15:0]               red;
   logic [14:0]               lo, hi, v;
   logic signed [16:0]        diff;
   logic signed [PROD_W-1:0]  shv;
   logic signed [PROD_W-1:0]  res;

   assign rng = (MIX_W + 1)'(mx_ff) - (MIX_W + 1)'(mn_ff);
   assign lo  = (req_ff.armed && !req_ff.grounded) ? IDLE_TAB[cfg.idle_percent] : '0;
   assign hi  = LIMIT_TAB[cfg.limit_percent];

   assign status.boost_en   = (cfg.torque_boost_gain != '0);
   assign status.brushless  = cfg.brushless_mode;
   assign status.skip_scale = req_ff.grounded || !req_ff.airborne;
   assign status.range_big  = (rng > (MIX_W + 1)'(ONE));

   always_comb begin
      mix_in  = mix_ff;
      hist_in = hist_ff;
      filt_in = filt_ff;
      mn_in   = mn_ff;
      mx_in   = mx_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      out_in  = out_ff;
      sum_in  = sum_ff;
      rsp_in  = rsp_ff;
      r_s = 18'(req_ff.roll_corr);
      p_s = 18'(req_ff.pitch_corr);
      y_s = cfg.yaw_flip ? -18'(req_ff.yaw_corr) : 18'(req_ff.yaw_corr);
      if (!cfg.plus_layout) begin
         raw[0] = 24'(-r_s - p_s + y_s);
         raw[1] = 24'(r_s - p_s - y_s);
         raw[2] = 24'(-r_s + p_s - y_s);
         raw[3] = 24'(r_s + p_s + y_s);
      end else begin
         raw[0] = 24'(-p_s + y_s);
         raw[1] = 24'(r_s - y_s);
         raw[2] = 24'(-r_s - y_s);
         raw[3] = 24'(p_s + y_s);
      end
      t_s   = '0;
      sum_s = '0;
      bprod = '0;
      num   = NUM_W'(mix_ff[cmd.mot]) <<< (FRAC_BITS + 1);
      num   = num + NUM_W'(rng);
      mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      trial = {rem_ff[REM_W-2:0], quo_ff[QB-1]};
      qv    = MIX_W'(quo_ff);
      qc    = qv + MIX_W'(rem_ff != '0);
      thr_s = (MIX_W + 2)'({1'b0, req_ff.throttle_in});
      lo_b  = -(MIX_W + 2)'(mn_ff);
      hi_b  = (MIX_W + 2)'(ONE) - (MIX_W + 2)'(mx_ff);
      st    = thr_s;
      acc   = '0;
      fv    = MIX_W'(filt_ff);
      rx    = 17'({filt_ff, 1'b0}) + 17'd10;
      rprod = 34'(rx) * 34'(RED_RECIP);
      red   = 16'(rprod >> RED_SHIFT);
      v     = '0;
      diff  = 17'({2'b00, hi}) - 17'({2'b00, lo});
      shv   = (prod_ff + PROD_W'(HALF)) >>> FRAC_BITS;
      res   = shv + PROD_W'({1'b0, lo});
      case (cmd.op)
         OP_MIX: begin
            for (int i = 0; i < MOTORS; i++) begin
               mix_in[i] = MIX_W'(sat16(raw[i]));
            end
            sum_in = '0;
         end
         OP_BOOST: begin
            // Difference filter over the current and the last four demands of each motor.
            for (int i = 0; i < MOTORS; i++) begin
               t_s = 24'(mix_ff[i]) + 24'(2 * 24'(hist_ff[i][0]))
                     - 24'(2 * 24'(hist_ff[i][2])) - 24'(hist_ff[i][3]);
               bprod = 32'(t_s) * 32'(signed'({1'b0, cfg.torque_boost_gain}));
               sum_s = 24'(mix_ff[i]) + 24'((bprod + 32'sd64) >>> 7);
               mix_in[i]     = MIX_W'(sat16(sum_s));
               hist_in[i][3] = hist_ff[i][2];
               hist_in[i][2] = hist_ff[i][1];
               hist_in[i][1] = hist_ff[i][0];
               hist_in[i][0] = mix_ff[i][15:0];
            end
         end
         OP_EXT: begin
            mn_in = mix_ff[0];
            mx_in = mix_ff[0];
            for (int i = 1; i < MOTORS; i++) begin
               if (mix_ff[i] < mn_in) begin
                  mn_in = mix_ff[i];
               end
               if (mix_ff[i] > mx_in) begin
                  mx_in = mix_ff[i];
               end
            end
         end
         OP_DLOAD: begin
            neg_in = num[NUM_W-1];
            rem_in = REM_W'(mag >> QB);
            quo_in = mag[QB-1:0];
            den_in = REM_W'(rng) << 1;
         end
         OP_DITER: begin
            if (trial >= den_ff) begin
               rem_in = trial - den_ff;
               quo_in = {quo_ff[QB-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[QB-2:0], 1'b0};
            end
         end
         OP_DWB: begin
            // Floor of a negative quotient steps down when a remainder is left.
            mix_in[cmd.mot] = neg_ff ? -qc : qv;
         end
         OP_THR: begin
            if (st < lo_b) begin
               st = lo_b;
            end
            if (st > hi_b) begin
               st = hi_b;
            end
            for (int i = 0; i < MOTORS; i++) begin
               mix_in[i] = MIX_W'((MIX_W + 2)'(mix_ff[i]) + st);
            end
         end
         OP_BADD: begin
            for (int i = 0; i < MOTORS; i++) begin
               mix_in[i] = mix_ff[i] + MIX_W'({1'b0, req_ff.throttle_in});
            end
         end
         OP_BOVER: begin
            for (int i = 0; i < MOTORS; i++) begin
               if (mix_ff[i] > acc) begin
                  acc = mix_ff[i];
               end
            end
            acc = acc - MIX_W'(ONE);
            if (acc > MIX_W'(HALF)) begin
               acc = MIX_W'(HALF);
            end
            if (acc > fv) begin
               fv = fv + MIX_W'(FILT_UP);
            end else begin
               fv = fv - MIX_W'(FILT_DN);
            end
            if (fv < -MIX_W'(FILT_LO)) begin
               fv = -MIX_W'(FILT_LO);
            end
            if (fv > MIX_W'(HALF)) begin
               fv = MIX_W'(HALF);
            end
            filt_in = 16'(fv);
         end
         OP_BRED: begin
            if (filt_ff > 16'sd0 && red != '0) begin
               for (int i = 0; i < MOTORS; i++) begin
                  mix_in[i] = mix_ff[i] - MIX_W'(red);
               end
            end
         end
         OP_BLIFT: begin
            if (req_ff.airborne) begin
               for (int i = 0; i < MOTORS; i++) begin
                  if (mix_ff[i] < acc) begin
                     acc = mix_ff[i];
                  end
               end
               if (acc < -MIX_W'(LIFT_MAX)) begin
                  acc = -MIX_W'(LIFT_MAX);
               end
               for (int i = 0; i < MOTORS; i++) begin
                  mix_in[i] = mix_ff[i] - acc;
               end
            end
         end
         OP_MUL: begin
            if (mix_ff[cmd.mot] < 0) begin
               v = '0;
            end else if (mix_ff[cmd.mot] > MIX_W'(ONE)) begin
               v = 15'(ONE);
            end else begin
               v = mix_ff[cmd.mot][14:0];
            end
            prod_in = PROD_W'(signed'({1'b0, v})) * PROD_W'(diff);
         end
         OP_ACC: begin
            if (res < 0) begin
               res = '0;
            end
            out_in[cmd.mot] = res[14:0];
            sum_in = sum_ff + SUM_W'(res[14:0]);
         end
         OP_EMIT: begin
            rsp_in.motor_front_right = out_ff[0];
            rsp_in.motor_front_left  = out_ff[1];
            rsp_in.motor_back_right  = out_ff[2];
            rsp_in.motor_back_left   = out_ff[3];
            rsp_in.throttle_average  = sum_ff[16:2];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         req_ff <= req_payload;
      end
      mix_in_copy: for (int i = 0; i < MOTORS; i++) begin
         mix_ff[i] <= mix_in[i];
         out_ff[i] <= out_in[i];
      end
      mn_ff   <= mn_in;
      mx_ff   <= mx_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= '0;
         for (int i = 0; i < MOTORS; i++) begin
            for (int k = 0; k < TAPS; k++) begin
               hist_ff[i][k] <= '0;
            end
         end
      end else begin
         filt_ff <= filt_in;
         hist_ff <= hist_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/quad_motor_mixer_unit.sv =====
// Top level of the quad motor mixer: configuration registers, sequencer and datapath.
//
// One transaction on req_ carries roll, pitch and yaw corrections, throttle
// and the flight flags; one transaction on rsp_ returns four motor commands
// and their average, all unsigned Q1.14. Both channels use valid/ready.
// The csr_ port writes a configuration register in the cycle csr_we is high;
// write it only while no transaction is in flight.
// Items are processed one at a time. Every transaction runs the mix step and
// the per-motor output scaling; the boost filter adds a step, airmode adds the
// extent, decide and throttle steps, and brushed scaling adds the throttle
// add, over-throttle, reduction and lift steps. Brushless airmode with a demand
// range above full scale also divides all four demands through one shared
// restoring divider, one quotient bit a cycle, one motor after another.
// req_ready is high whenever the sequencer is idle, so the next transaction
// can be taken in the same cycle that rsp_valid rises.
// The result sits in an output register, so a new request is taken while the
// previous result waits; if rsp_ready stays low the sequencer holds its
// finished result until the register drains.
// Synchronous reset clears the boost history, the over-throttle filter and
// the configuration to its defaults, and leaves the block idle.
`include "quad_motor_mixer_unit_assert.svh"

module quad_motor_mixer_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qmm_pkg::qmm_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qmm_pkg::qmm_rsp_type rsp_payload,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_wdata
);
   import qmm_pkg::*;

   qmm_cfg_type    cfg_ff, cfg_in;
   qmm_cmd_type    cmd;
   qmm_status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAIN:      cfg_in.torque_boost_gain = csr_wdata;
            CSR_INV_YAW:   cfg_in.yaw_flip          = csr_wdata[0];
            CSR_PLUS:      cfg_in.plus_layout       = csr_wdata[0];
            CSR_BRUSHLESS: cfg_in.brushless_mode    = csr_wdata[0];
            CSR_IDLE:      cfg_in.idle_percent      = csr_wdata[6:0];
            CSR_LIMIT:     cfg_in.limit_percent     = csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.torque_boost_gain <= '0;
         cfg_ff.yaw_flip          <= 1'b0;
         cfg_ff.plus_layout       <= 1'b0;
         cfg_ff.brushless_mode    <= 1'b1;
         cfg_ff.idle_percent      <= '0;
         cfg_ff.limit_percent     <= 7'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   qmm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   `QMM_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `QMM_ASSERT_SAME(a_emit_when_free, cmd.op == OP_EMIT, !rsp_valid || rsp_ready)
   `QMM_ASSERT_NEXT(a_emit_shows_result, cmd.op == OP_EMIT, rsp_valid)
   `QMM_ASSERT_SAME(a_divide_only_wide, cmd.op == OP_DITER, status.range_big)

endmodule

// ===== verif/quad_motor_mixer_unit_checker.sv =====
// Checker for the quad motor mixer: predicts each result and compares it.
module quad_motor_mixer_unit_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  qmm_pkg::qmm_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  qmm_pkg::qmm_rsp_type rsp_payload,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   output int                   fail_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import qmm_pkg::*;

   localparam longint UNITY = 16384;

   qmm_cfg_type cfg;
   logic signed [15:0] tap_line [MOTORS][TAPS];
   longint filt;
   qmm_rsp_type motor_queue [$];

   function automatic longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint rnd(longint a, longint b);
      return fdiv(2 * a + b, 2 * b);
   endfunction

   function automatic longint clip(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   function automatic qmm_rsp_type mix_motors(qmm_req_type t);
      longint r, p, y, thr, lo, hi, sum, mn, mx, rng, smin, smax, over, under, v, tt, red;
      longint d [MOTORS];
      longint o [MOTORS+1];
      qmm_rsp_type res;
      r = longint'(t.roll_corr);
      p = longint'(t.pitch_corr);
      y = longint'(t.yaw_corr);
      thr = longint'(t.throttle_in);
      if (cfg.yaw_flip) y = -y;
      if (!cfg.plus_layout) begin
         d[0] = -r - p + y; d[1] = r - p - y; d[2] = -r + p - y; d[3] = r + p + y;
      end else begin
         d[0] = -p + y; d[1] = r - y; d[2] = -r - y; d[3] = p + y;
      end
      for (int i = 0; i < MOTORS; i++) d[i] = clip(d[i], -32768, 32767);
      if (cfg.torque_boost_gain != 0) begin
         for (int i = 0; i < MOTORS; i++) begin
            tt = d[i] + 2 * tap_line[i][0] - 2 * tap_line[i][2] - tap_line[i][3];
            v = rnd(tt * cfg.torque_boost_gain, 128);
            tap_line[i][3] = tap_line[i][2];
            tap_line[i][2] = tap_line[i][1];
            tap_line[i][1] = tap_line[i][0];
            tap_line[i][0] = 16'(d[i]);
            d[i] = clip(d[i] + v, -32768, 32767);
         end
      end
      if (cfg.brushless_mode) begin
         if (!t.grounded && t.airborne) begin
            mn = d[0]; mx = d[0];
            for (int i = 1; i < MOTORS; i++) begin
               if (d[i] < mn) mn = d[i];
               if (d[i] > mx) mx = d[i];
            end
            rng = mx - mn;
            if (rng > UNITY) begin
               for (int i = 0; i < MOTORS; i++) d[i] = rnd(d[i] * UNITY, rng);
               smin = rnd(mn * UNITY, rng);
               smax = rnd(mx * UNITY, rng);
            end else begin
               smin = mn; smax = mx;
            end
            // Lower bound first, so the upper bound wins when they cross.
            v = thr;
            if (v < -smin) v = -smin;
            if (v > UNITY - smax) v = UNITY - smax;
            for (int i = 0; i < MOTORS; i++) d[i] += v;
         end
      end else begin
         over = 0; under = 0;
         for (int i = 0; i < MOTORS; i++) begin
            d[i] += thr;
            if (d[i] > over) over = d[i];
         end
         over -= UNITY;
         if (over > UNITY / 2) over = UNITY / 2;
         if (over > filt) filt += 82; else filt -= 164;
         filt = clip(filt, -1638, UNITY / 2);
         if (filt > 0) begin
            red = rnd(filt, 10);
            if (red > 0) for (int i = 0; i < MOTORS; i++) d[i] -= red;
         end
         if (t.airborne) begin
            for (int i = 0; i < MOTORS; i++) if (d[i] < under) under = d[i];
            if (under < -3277) under = -3277;
            if (under < 0) for (int i = 0; i < MOTORS; i++) d[i] -= under;
         end
      end
      lo = 0;
      if (!t.grounded && t.armed) lo = rnd((1 + 100 * longint'(cfg.idle_percent)) * UNITY, 10000);
      hi = rnd(longint'(cfg.limit_percent) * UNITY, 100);
      sum = 0;
      for (int i = 0; i < MOTORS; i++) begin
         v = clip(d[i], 0, UNITY);
         v = lo + rnd(v * (hi - lo), UNITY);
         if (v < 0) v = 0;
         sum += v;
         o[i] = v;
      end
      o[MOTORS] = sum / 4;
      res.motor_front_right = 15'(o[0]);
      res.motor_front_left  = 15'(o[1]);
      res.motor_back_right  = 15'(o[2]);
      res.motor_back_left   = 15'(o[3]);
      res.throttle_average  = 15'(o[4]);
      return res;
   endfunction

   assign pending_count = motor_queue.size();

   always @(posedge clock) begin
      qmm_rsp_type want;
      if (reset) begin
         cfg <= '{torque_boost_gain: 8'd0, yaw_flip: 1'b0, plus_layout: 1'b0,
                  brushless_mode: 1'b1, idle_percent: 7'd0, limit_percent: 7'd100};
         for (int m = 0; m < MOTORS; m++) for (int k = 0; k < TAPS; k++) tap_line[m][k] = '0;
         filt = 0;
         motor_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GAIN:      cfg.torque_boost_gain <= csr_wdata;
               CSR_INV_YAW:   cfg.yaw_flip <= csr_wdata[0];
               CSR_PLUS:      cfg.plus_layout <= csr_wdata[0];
               CSR_BRUSHLESS: cfg.brushless_mode <= csr_wdata[0];
               CSR_IDLE:      cfg.idle_percent <= csr_wdata[6:0];
               CSR_LIMIT:     cfg.limit_percent <= csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) motor_queue.push_back(mix_motors(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (motor_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transaction %h", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = motor_queue.pop_front();
               if (want !== rsp_payload) begin
                  if (fail_count < 10)
                     $display("mismatch: fr %0d/%0d fl %0d/%0d br %0d/%0d bl %0d/%0d avg %0d/%0d",
                        want.motor_front_right, rsp_payload.motor_front_right,
                        want.motor_front_left, rsp_payload.motor_front_left,
                        want.motor_back_right, rsp_payload.motor_back_right,
                        want.motor_back_left, rsp_payload.motor_back_left,
                        want.throttle_average, rsp_payload.throttle_average);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== verif/quad_motor_mixer_unit_tb.sv =====
// Testbench top for the quad motor mixer: stimulus, configuration and verdict.
module quad_motor_mixer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qmm_pkg::*;

   logic clock, reset, req_valid, req_ready, rsp_valid, rsp_ready, csr_we;
   qmm_req_type req_payload;
   qmm_rsp_type rsp_payload;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;
   int fail_count, pending_count;
   longint cycle_count = 0;
   bit stall_on;

   quad_motor_mixer_unit uut (.*);
   quad_motor_mixer_unit_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("quad_motor_mixer_unit_tb: done, errors");
         $finish;
      end
   end

   // The receiver draws a stall length per result.
   initial begin
      int wait_n;
      rsp_ready = 0;
      @(posedge clock iff !reset);
      forever begin
         wait_n = stall_on ? $urandom_range(0, 16) : 0;
         if (wait_n != 0) begin
            rsp_ready <= 0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock iff rsp_valid);
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic send_item(input qmm_req_type t, input bit gaps);
      int wait_n;
      wait_n = gaps ? $urandom_range(0, 16) : 0;
      if (wait_n != 0) begin
         req_valid <= 0;
         repeat (wait_n) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= t;
      @(posedge clock iff req_ready);
   endtask

   function automatic qmm_req_type random_item();
      qmm_req_type t;
      t.roll_corr = 16'($urandom);
      t.pitch_corr = 16'($urandom);
      t.yaw_corr = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
         t.roll_corr = 16'(int'($urandom_range(0, 8000)) - 4000);
         t.pitch_corr = 16'(int'($urandom_range(0, 8000)) - 4000);
         t.yaw_corr = 16'(int'($urandom_range(0, 8000)) - 4000);
      end
      t.throttle_in = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
      t.grounded = ($urandom_range(0, 3) == 0);
      t.airborne = ($urandom_range(0, 3) != 0);
      t.armed = ($urandom_range(0, 4) != 0);
      return t;
   endfunction

   initial begin
      qmm_req_type t;
      logic signed [15:0] ext [4];
      int k;
      ext = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1};
      stall_on = 1;
      reset = 1; req_valid = 0; req_payload = '0; csr_we = 0; csr_index = '0; csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed items: field extremes under the reset settings and then brushed with boost.
      for (int ph = 0; ph < 2; ph++) begin
         if (ph == 1) begin
            write_reg(CSR_GAIN, 8'd255);
            write_reg(CSR_BRUSHLESS, 8'd0);
            write_reg(CSR_IDLE, 8'd127);
            write_reg(CSR_LIMIT, 8'd0);
         end
         for (int i = 0; i < 12; i++) begin
            t.roll_corr = ext[i % 4];
            t.pitch_corr = ext[(i / 4 + i) % 4];
            t.yaw_corr = ext[(i + 2) % 4];
            t.throttle_in = (i % 3 == 0) ? 15'h7fff : (i % 3 == 1) ? 15'd16384 : 15'd0;
            t.grounded = i[0];
            t.airborne = i[1];
            t.armed = i[2];
            send_item(t, 0);
         end
         drain_results();
      end
      // Random phases across the settings, with extremes included.
      for (int ph = 0; ph < 13; ph++) begin
         write_reg(CSR_GAIN, (ph % 4 == 0) ? 8'd0 : (ph % 4 == 1) ? 8'd255 : 8'($urandom));
         write_reg(CSR_INV_YAW, 8'(ph % 2));
         write_reg(CSR_PLUS, 8'((ph / 2) % 2));
         write_reg(CSR_BRUSHLESS, 8'((ph / 3) % 2));
         write_reg(CSR_IDLE, (ph == 5) ? 8'd100 : (ph == 6) ? 8'd127 : 8'($urandom_range(0, 20)));
         write_reg(CSR_LIMIT, (ph == 7) ? 8'd0 : (ph == 8) ? 8'd127 : 8'($urandom_range(60, 100)));
         stall_on = (ph != 3);
         for (k = 0; k < 100; k++) begin
            send_item(random_item(), ph != 4);
            // Let the sender wait for every outstanding result once.
            if (ph == 2 && k == 50) begin
               req_valid <= 0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
         end
         drain_results();
      end
      if (fail_count == 0) begin
         $display("quad_motor_mixer_unit_tb: done, clean");
      end else begin
         $display("quad_motor_mixer_unit_tb: done, errors");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qmm_pkg.sv
rtl/core/qmm_ctrl.sv
rtl/core/qmm_datapath.sv
rtl/core/quad_motor_mixer_unit.sv
verif/quad_motor_mixer_unit_checker.sv
verif/quad_motor_mixer_unit_tb.sv
